### sv/pad_pkg.sv
// Package for the peer address directory: action and status codes, the
// classified command that travels from front to back, and the state encodings.
// No dependencies.
`default_nettype none

package pad_pkg;

    // Request actions as they arrive on the command port.
    localparam logic [2:0] ACT_ADDR_REQ = 3'd0;
    localparam logic [2:0] ACT_LOOKUP   = 3'd1;
    localparam logic [2:0] ACT_DESTRUCT = 3'd2;
    localparam logic [2:0] ACT_CTX_INIT = 3'd5;
    localparam logic [2:0] ACT_CTX_REQ  = 3'd6;

    // Reply status codes.
    localparam logic [2:0] ST_NUMBER = 3'd0;
    localparam logic [2:0] ST_RETRY  = 3'd1;
    localparam logic [2:0] ST_ACK    = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    // Command queue between front and back.
    localparam int Q_DEPTH = 2;

    // Work kinds after classification by the front.
    typedef enum logic [2:0] {
        K_ADDR,
        K_LOOKUP,
        K_INIT,
        K_CREQ,
        K_FULL,
        K_RETRY,
        K_EMPTY
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [8:0]  size;
        logic [3:0]  group;
        logic [31:0] handle;
        logic [7:0]  peer;
    } t_cmd;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_back_state;

endpackage

`default_nettype wire

### sv/pad_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module pad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### sv/pad_front.sv
// Front end of the peer address directory: takes requests and classifies
// them, settling range checks early. Depends on pad_pkg.
`default_nettype none

module pad_front
    import pad_pkg::*;
#(
    parameter int MAX_GROUPS = 16,
    parameter int MAX_PEERS  = 256
) (
    input  wire logic        i_start,
    input  wire logic        i_q_full,
    input  wire logic [2:0]  i_action,
    input  wire logic [8:0]  i_group_size,
    input  wire logic [3:0]  i_group_id,
    input  wire logic [31:0] i_endpoint_handle,
    input  wire logic [7:0]  i_remote_address,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic group_ok;
    logic peer_ok;

    assign group_ok = 32'(i_group_id) < 32'(MAX_GROUPS);
    assign peer_ok  = 32'(i_remote_address) < 32'(MAX_PEERS);
    assign o_push   = i_start && !i_q_full;

    always_comb begin
        o_cmd.size   = i_group_size;
        o_cmd.group  = i_group_id;
        o_cmd.handle = i_endpoint_handle;
        o_cmd.peer   = i_remote_address;
        unique case (i_action)
            ACT_CTX_INIT: o_cmd.kind = K_INIT;
            ACT_CTX_REQ:  o_cmd.kind = K_CREQ;
            ACT_ADDR_REQ: o_cmd.kind = group_ok ? K_ADDR : K_FULL;
            ACT_LOOKUP:   o_cmd.kind = (group_ok && peer_ok) ? K_LOOKUP : K_RETRY;
            default:      o_cmd.kind = K_EMPTY;
        endcase
    end

endmodule

`default_nettype wire

### sv/pad_fifo.sv
// Two-entry command queue between the front and the back.
// Depends on pad_pkg.
`default_nettype none

module pad_fifo
    import pad_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_empty,
    output logic      o_full
);

    t_cmd       r_mem [0:Q_DEPTH-1];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_cmd   = r_mem[r_rptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'(Q_DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

### sv/pad_back.sv
// Back end of the peer address directory: counter and handle stores, group
// bookkeeping and the reply register. Depends on pad_pkg and pad_ram.
`default_nettype none

module pad_back
    import pad_pkg::*;
#(
    parameter int MAX_GROUPS  = 16,
    parameter int MAX_PEERS   = 256,
    parameter int HANDLE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic        i_q_empty,
    output logic             o_pop,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [7:0]       o_number,
    output logic [31:0]      o_found_handle
);

    localparam int GW  = $clog2(MAX_GROUPS);
    localparam int CW  = $clog2(MAX_PEERS + 1);
    // Only groups below 16 and peers below 256 can be named by a request.
    localparam int EG  = (MAX_GROUPS < 16) ? MAX_GROUPS : 16;
    localparam int EP  = (MAX_PEERS < 256) ? MAX_PEERS : 256;
    localparam int EGW = $clog2(EG);
    localparam int EPW = $clog2(EP);
    localparam int HW  = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;

    t_back_state r_state;
    t_back_state n_state;
    t_cmd        r_cmd;
    logic [GW-1:0] r_cnt_addr;
    logic [GW-1:0] r_highest;
    logic [GW-1:0] n_highest;
    logic [GW-1:0] r_open;
    logic [GW-1:0] n_open;
    logic [MAX_GROUPS-1:0] r_cnt_vld;
    logic [EPW:0]  r_hw [0:EG-1];

    logic          r_valid;
    logic          n_valid;
    logic [2:0]    r_status;
    logic [2:0]    n_status;
    logic [7:0]    r_number;
    logic [7:0]    n_number;
    logic [31:0]   r_handle;
    logic [31:0]   n_handle;

    // Counter store.
    logic          cnt_we;
    logic [GW-1:0] cnt_waddr;
    logic [CW-1:0] cnt_wdata;
    logic [GW-1:0] cnt_raddr;
    logic [CW-1:0] cnt_rdata;

    // Handle store.
    logic                hnd_we;
    logic [EGW+EPW-1:0]  hnd_waddr;
    logic [EGW+EPW-1:0]  hnd_raddr;
    logic [HW-1:0]       hnd_rdata;

    logic          hw_we;
    logic [EPW:0]  hw_wdata;

    logic [8:0]    head_group_x;
    logic [CW-1:0] cnt;
    logic [16:0]   cnt_x;
    logic [GW:0]   fresh_x;
    logic          fresh_ok;
    logic [GW-1:0] fresh_g;
    logic [EGW-1:0] cmd_eg;
    logic [EPW:0]  hw_g;

    assign head_group_x = 9'(i_cmd.group);
    assign cmd_eg       = r_cmd.group[EGW-1:0];
    assign cnt          = r_cnt_vld[r_cnt_addr] ? cnt_rdata : '0;
    assign cnt_x        = 17'(cnt);
    assign fresh_x      = {1'b0, r_highest} + {{GW{1'b0}}, 1'b1};
    assign fresh_ok     = fresh_x < (GW+1)'(MAX_GROUPS);
    assign fresh_g      = fresh_x[GW-1:0];
    assign hw_g         = r_hw[cmd_eg];

    assign cnt_raddr = (i_cmd.kind == K_INIT) ? r_open : head_group_x[GW-1:0];
    assign hnd_raddr = {i_cmd.group[EGW-1:0], i_cmd.peer[EPW-1:0]};

    pad_ram #(
        .WIDTH (CW),
        .DEPTH (2 ** GW)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    pad_ram #(
        .WIDTH (HW),
        .DEPTH (2 ** (EGW + EPW))
    ) u_hnd_ram (
        .i_clk   (i_clk),
        .i_we    (hnd_we),
        .i_waddr (hnd_waddr),
        .i_wdata (r_cmd.handle[HW-1:0]),
        .i_raddr (hnd_raddr),
        .o_rdata (hnd_rdata)
    );

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = i_q_empty ? S_IDLE : S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        n_valid   = 1'b0;
        n_status  = ST_EMPTY;
        n_number  = 8'd0;
        n_handle  = 32'd0;
        n_highest = r_highest;
        n_open    = r_open;
        cnt_we    = 1'b0;
        cnt_waddr = r_cnt_addr;
        cnt_wdata = '0;
        hnd_we    = 1'b0;
        hnd_waddr = {cmd_eg, cnt[EPW-1:0]};
        hw_we     = 1'b0;
        hw_wdata  = (EPW+1)'(cnt) + (EPW+1)'(1);
        unique case (r_state)
            S_IDLE: begin
                o_pop = !i_q_empty;
            end
            S_EXEC: begin
                n_valid = 1'b1;
                case (r_cmd.kind)
                    K_INIT: begin
                        if (cnt_x == 17'(r_cmd.size)) begin
                            if (fresh_ok) begin
                                n_highest = fresh_g;
                                n_open    = fresh_g;
                                cnt_we    = 1'b1;
                                cnt_waddr = fresh_g;
                                n_status  = ST_NUMBER;
                                n_number  = 8'(fresh_g);
                            end else begin
                                n_status = ST_FULL;
                            end
                        end else begin
                            n_status = ST_NUMBER;
                            n_number = 8'(r_open);
                        end
                    end
                    K_CREQ: begin
                        if (fresh_ok) begin
                            n_highest = fresh_g;
                            cnt_we    = 1'b1;
                            cnt_waddr = fresh_g;
                            n_status  = ST_NUMBER;
                            n_number  = 8'(fresh_g);
                        end else begin
                            n_status = ST_FULL;
                        end
                    end
                    K_ADDR: begin
                        if (cnt_x >= 17'(MAX_PEERS)) begin
                            n_status = ST_FULL;
                        end else begin
                            cnt_we    = 1'b1;
                            cnt_wdata = cnt + {{(CW-1){1'b0}}, 1'b1};
                            n_status  = ST_NUMBER;
                            n_number  = cnt_x[7:0];
                            // Addresses past the lookup range are counted but never filed.
                            if (cnt_x < 17'(EP)) begin
                                hnd_we = 1'b1;
                                hw_we  = (hw_wdata > hw_g);
                            end
                        end
                    end
                    K_LOOKUP: begin
                        // Filed addresses of a group always form a prefix.
                        if (9'(r_cmd.peer) < 9'(hw_g)) begin
                            n_status = ST_ACK;
                            n_handle = 32'(hnd_rdata);
                        end else begin
                            n_status = ST_RETRY;
                        end
                    end
                    K_FULL:  n_status = ST_FULL;
                    K_RETRY: n_status = ST_RETRY;
                    default: n_status = ST_EMPTY;
                endcase
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_highest <= '0;
            r_open    <= '0;
            r_cnt_vld <= '0;
            r_valid   <= 1'b0;
            for (int i = 0; i < EG; i++) begin
                r_hw[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_highest <= n_highest;
            r_open    <= n_open;
            r_valid   <= n_valid;
            if (cnt_we) begin
                r_cnt_vld[cnt_waddr] <= 1'b1;
            end
            if (hw_we) begin
                r_hw[cmd_eg] <= hw_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd      <= i_cmd;
            r_cnt_addr <= cnt_raddr;
        end
        r_status <= n_status;
        r_number <= n_number;
        r_handle <= n_handle;
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_number       = r_number;
    assign o_found_handle = r_handle;

endmodule

`default_nettype wire

### sv/peer_address_directory_top.sv
// Top level of the peer address directory: front, command queue and back.
// Depends on pad_pkg, pad_front, pad_fifo, pad_back and pad_ram.
//
// Usage. A request is transferred at a rising edge where start is high and
// busy is low; its fields are action, group size, group id, endpoint handle
// and remote address. Every request produces exactly one reply, shown on
// o_status, o_number and o_found_handle for one cycle while o_valid is high.
// The receiver cannot hold replies off, so there is no output back pressure.
//
// The front classifies a request in the cycle it is transferred and places it
// in a two-entry queue. The back pops one command, reads the group counter
// store and the handle store (both RAMs with registered reads) in that cycle,
// and in the next cycle updates state and loads the reply register. The back
// pops a new command only from its idle state, so it cannot take a new
// request before it is through with the last; busy rises when the queue holds
// two requests. Lookups see which addresses are filed through a per-group
// fill count, so no clearing pass is needed.
//
// Reset is synchronous and active low. It empties the queue, returns group
// numbering to zero and marks every counter and every filing as empty; busy is
// low in the first cycle after reset.
`default_nettype none

module peer_address_directory_top
    import pad_pkg::*;
#(
    parameter int MAX_GROUPS  = 16,
    parameter int MAX_PEERS   = 256,
    parameter int HANDLE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_action,
    input  wire logic [8:0]  i_group_size,
    input  wire logic [3:0]  i_group_id,
    input  wire logic [31:0] i_endpoint_handle,
    input  wire logic [7:0]  i_remote_address,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [7:0]       o_number,
    output logic [31:0]      o_found_handle
);

    logic push;
    logic pop;
    logic q_empty;
    logic q_full;
    t_cmd front_cmd;
    t_cmd head_cmd;

    // Busy is simply the queue being full.
    assign busy = q_full;

    pad_front #(
        .MAX_GROUPS (MAX_GROUPS),
        .MAX_PEERS  (MAX_PEERS)
    ) u_front (
        .i_start           (start),
        .i_q_full          (q_full),
        .i_action          (i_action),
        .i_group_size      (i_group_size),
        .i_group_id        (i_group_id),
        .i_endpoint_handle (i_endpoint_handle),
        .i_remote_address  (i_remote_address),
        .o_push            (push),
        .o_cmd             (front_cmd)
    );

    pad_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    pad_back #(
        .MAX_GROUPS  (MAX_GROUPS),
        .MAX_PEERS   (MAX_PEERS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (head_cmd),
        .i_q_empty      (q_empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_number       (o_number),
        .o_found_handle (o_found_handle)
    );

    // The back returns to idle after each command before it pops the next, so replies never come back to back.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two replies in consecutive cycles");

    // Only an ack carries a handle.
    a_handle_only_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_ACK)) |-> (o_found_handle == 32'd0))
        else $error("handle returned without ack");

    // Only a number reply carries a number.
    a_number_only_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_NUMBER)) |-> (o_number == 8'd0))
        else $error("number returned with a non-number reply");

    // A full queue can only follow a transfer in the previous cycle.
    a_full_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(push))
        else $error("queue filled without a transfer");

endmodule

`default_nettype wire
